@@ hdl/gha_pkg.sv @@
// Types, codes and sizes shared by the generational handle allocator.
package gha_pkg;

    // Table sizes
    localparam int unsigned SLOTS  = 256;
    localparam int unsigned SLOT_W = 9;
    localparam int unsigned ADDR_W = 8;
    localparam int unsigned GEN_W  = 32;

    localparam logic [SLOT_W-1:0] SLOTS_V = SLOT_W'(SLOTS);

    // Operation codes
    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_CHECK   = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BAD  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [SLOT_W-1:0] slot_id;
        logic [GEN_W-1:0]  handle_generation;
    } request_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] out_slot;
        logic [GEN_W-1:0]  out_generation;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GEN_RD
    } state_t;

endpackage

@@ hdl/generational_handle_allocator.sv @@
// Generational handle allocator: slot table with LIFO free stack.
//
// A request is taken at a rising edge where start is high and busy is low.
// Its fields are func (allocate, release, check), slot_id and
// handle_generation. Exactly one result comes back per request: it sits on
// the result port for one cycle with done high, and is taken at the edge
// that ends that cycle. The receiver has no way to hold it off.
//
// Sequence: check, release, a fresh allocate and a full allocate show done
// as the block leaves ST_EXEC, and busy drops in that same cycle, so a new
// request can be taken while done is high. An allocate that pops the free
// stack passes through ST_GEN_RD as well: the slot read from the stack
// memory must address the generation memory in a second read, each memory
// having a registered read.
//
// Reset clears the high-water mark, the free stack depth and the control
// state; both memories keep their contents and are only read at entries
// that have been written since. No clearing pass is needed.
module generational_handle_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  gha_pkg::request_t   request,
    output logic                busy,
    output logic                done,
    output gha_pkg::result_t    result
);

    // Memories
    logic [gha_pkg::GEN_W-1:0]  gen_mem   [gha_pkg::SLOTS];
    logic [gha_pkg::SLOT_W-1:0] stack_mem [gha_pkg::SLOTS];

    gha_pkg::state_t             state_reg, state_next;
    gha_pkg::request_t           req_reg;
    gha_pkg::result_t            rsp_reg, rsp_next;
    logic                        done_reg, done_next;
    logic [gha_pkg::SLOT_W-1:0]  high_water_reg, high_water_next;
    logic [gha_pkg::SLOT_W-1:0]  free_depth_reg, free_depth_next;
    logic [gha_pkg::GEN_W-1:0]   gen_rd_reg;
    logic [gha_pkg::SLOT_W-1:0]  stack_rd_reg;

    logic                        accept;
    logic                        live;
    logic                        gen_we;
    logic [gha_pkg::ADDR_W-1:0]  gen_waddr;
    logic [gha_pkg::GEN_W-1:0]   gen_wdata;
    logic [gha_pkg::ADDR_W-1:0]  gen_raddr;
    logic                        stack_we;
    logic [gha_pkg::SLOT_W-1:0]  req_slot_m1;
    logic [gha_pkg::SLOT_W-1:0]  held_slot_m1;
    logic [gha_pkg::SLOT_W-1:0]  pop_slot_m1;
    logic [gha_pkg::SLOT_W-1:0]  depth_m1;
    logic [gha_pkg::SLOT_W-1:0]  hw_p1;

    assign accept       = start && (state_reg == gha_pkg::ST_IDLE);
    assign req_slot_m1  = request.slot_id - gha_pkg::SLOT_W'(1);
    assign held_slot_m1 = req_reg.slot_id - gha_pkg::SLOT_W'(1);
    assign pop_slot_m1  = stack_rd_reg - gha_pkg::SLOT_W'(1);
    assign depth_m1     = free_depth_reg - gha_pkg::SLOT_W'(1);
    assign hw_p1        = high_water_reg + gha_pkg::SLOT_W'(1);

    // Address generation memory by request slot, or by popped slot
    assign gen_raddr = (state_reg == gha_pkg::ST_EXEC) ? pop_slot_m1[gha_pkg::ADDR_W-1:0]
                                                       : req_slot_m1[gha_pkg::ADDR_W-1:0];

    // Handle is live when nonzero, at or below high water and generation matches
    assign live = (req_reg.slot_id != '0) && (req_reg.slot_id <= high_water_reg)
                  && (gen_rd_reg == req_reg.handle_generation);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gha_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = gha_pkg::ST_EXEC;
                end
            end
            gha_pkg::ST_EXEC:
            begin
                if ((req_reg.func == gha_pkg::FUNC_ALLOC) && (free_depth_reg != '0))
                begin
                    state_next = gha_pkg::ST_GEN_RD;
                end
                else
                begin
                    state_next = gha_pkg::ST_IDLE;
                end
            end
            gha_pkg::ST_GEN_RD:
            begin
                state_next = gha_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gha_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs, memory writes and counter updates
    always_comb
    begin
        busy            = (state_reg != gha_pkg::ST_IDLE);
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        high_water_next = high_water_reg;
        free_depth_next = free_depth_reg;
        gen_we          = 1'b0;
        gen_waddr       = held_slot_m1[gha_pkg::ADDR_W-1:0];
        gen_wdata       = gen_rd_reg + gha_pkg::GEN_W'(1);
        stack_we        = 1'b0;
        case (state_reg)
            gha_pkg::ST_IDLE:
            begin
                done_next = 1'b0;
            end
            gha_pkg::ST_EXEC:
            begin
                rsp_next.status         = gha_pkg::STATUS_BAD;
                rsp_next.out_slot       = req_reg.slot_id;
                rsp_next.out_generation = req_reg.handle_generation;
                case (req_reg.func)
                    gha_pkg::FUNC_ALLOC:
                    begin
                        if (free_depth_reg != '0)
                        begin
                            // pop; result follows after the generation read
                            free_depth_next = depth_m1;
                        end
                        else if (high_water_reg < gha_pkg::SLOTS_V)
                        begin
                            // extend high water with a fresh generation
                            high_water_next         = hw_p1;
                            gen_we                  = 1'b1;
                            gen_waddr               = high_water_reg[gha_pkg::ADDR_W-1:0];
                            gen_wdata               = gha_pkg::GEN_W'(1);
                            rsp_next.status         = gha_pkg::STATUS_OK;
                            rsp_next.out_slot       = hw_p1;
                            rsp_next.out_generation = gha_pkg::GEN_W'(1);
                            done_next               = 1'b1;
                        end
                        else
                        begin
                            rsp_next.status         = gha_pkg::STATUS_FULL;
                            rsp_next.out_slot       = '0;
                            rsp_next.out_generation = '0;
                            done_next               = 1'b1;
                        end
                    end
                    gha_pkg::FUNC_RELEASE:
                    begin
                        done_next = 1'b1;
                        if (live && (free_depth_reg < gha_pkg::SLOTS_V))
                        begin
                            // bump generation and push slot
                            gen_we          = 1'b1;
                            stack_we        = 1'b1;
                            free_depth_next = free_depth_reg + gha_pkg::SLOT_W'(1);
                            rsp_next.status = gha_pkg::STATUS_OK;
                        end
                    end
                    gha_pkg::FUNC_CHECK:
                    begin
                        done_next = 1'b1;
                        if (live)
                        begin
                            rsp_next.status = gha_pkg::STATUS_OK;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            gha_pkg::ST_GEN_RD:
            begin
                rsp_next.status         = gha_pkg::STATUS_OK;
                rsp_next.out_slot       = stack_rd_reg;
                rsp_next.out_generation = gen_rd_reg;
                done_next               = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gha_pkg::ST_IDLE;
            done_reg       <= 1'b0;
            high_water_reg <= '0;
            free_depth_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            high_water_reg <= high_water_next;
            free_depth_reg <= free_depth_next;
        end
    end

    // Hold request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        rsp_reg <= rsp_next;
    end

    // Generation memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (gen_we)
        begin
            gen_mem[gen_waddr] <= gen_wdata;
        end
        gen_rd_reg <= gen_mem[gen_raddr];
    end

    // Free stack memory: read top of stack only when a request enters
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[free_depth_reg[gha_pkg::ADDR_W-1:0]] <= req_reg.slot_id;
        end
        if (accept)
        begin
            stack_rd_reg <= stack_mem[depth_m1[gha_pkg::ADDR_W-1:0]];
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    // A result only ever closes a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in flight");

    // A request keeps the block busy only through ST_EXEC and, for a pop, ST_GEN_RD
    a_busy_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && $past(busy)) |=> !busy)
        else $error("request held longer than a stack pop");

    // Counters stay within the table
    a_counters_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (high_water_reg <= gha_pkg::SLOTS_V) && (free_depth_reg <= gha_pkg::SLOTS_V))
        else $error("high water or free stack depth beyond table size");

    // A pop lowers the stack depth by one
    a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == gha_pkg::ST_EXEC) && (req_reg.func == gha_pkg::FUNC_ALLOC)
         && (free_depth_reg != '0))
        |=> (free_depth_reg == $past(depth_m1)))
        else $error("free stack pop did not decrement depth");

    // A release or check never moves the high-water mark
    a_hw_still: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == gha_pkg::ST_EXEC) && (req_reg.func != gha_pkg::FUNC_ALLOC))
        |=> $stable(high_water_reg))
        else $error("high water moved outside allocate");

endmodule
